/* rtl/core/itr_pkg.sv */
// Shared types, constants and helper functions of the integer to radix string converter.
`timescale 1ns / 1ps

package itr_pkg;

	localparam int MAX_DIGITS_DEF = 64;
	localparam int VALUE_BITS_DEF = 63;
	localparam int VALUE_W        = 63;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int RADIX_W        = 6;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 6;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIX        = 1'b0,
		CFG_LETTER_UPPER = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic cont;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
		logic quo_zero;
	} div_stat_t;

	// Saturate the programmed radix into 2..36.
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Map one digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] res;
		if (d < DEC_DIGITS) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d) - CHAR_W'(DEC_DIGITS);
		end
		return res;
	endfunction

endpackage

/* rtl/core/itr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module itr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/itr_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, the quotient replaces the dividend.
`timescale 1ns / 1ps

module itr_divider #(
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itr_pkg::div_ctrl_t            ctrl,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [itr_pkg::RADIX_W-1:0]   base,
	output itr_pkg::div_stat_t            stat,
	output logic [itr_pkg::DIGIT_W-1:0]   digit
);

	localparam int CW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0]       quo_q;
	logic [itr_pkg::DIGIT_W-1:0] rem_q;
	logic [CW-1:0]               cnt_q;
	logic                        run_q;
	logic                        nz_q;
	logic                        done_q;

	logic [itr_pkg::DIGIT_W:0]   trial;
	logic [itr_pkg::DIGIT_W:0]   diff;
	logic                        ge;
	logic [itr_pkg::DIGIT_W-1:0] rem_n;

	always_comb begin
		trial = {rem_q, quo_q[VALUE_BITS-1]};
		diff  = trial - {1'b0, base};
		ge    = (trial >= {1'b0, base});
		rem_n = ge ? diff[itr_pkg::DIGIT_W-1:0] : trial[itr_pkg::DIGIT_W-1:0];
	end

	// Dividend shifts out at the top, quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= value;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			nz_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.load || ctrl.cont) begin
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
				nz_q  <= 1'b0;
			end else if (run_q) begin
				rem_q <= rem_n;
				nz_q  <= nz_q | ge;
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done     = done_q;
	assign stat.quo_zero = !nz_q;
	assign digit         = rem_q;

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (rem_q < base))
		else $error("remainder reached the divisor");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("done without a running division");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q <= CW'(VALUE_BITS - 1)))
		else $error("bit counter out of range");

endmodule

/* rtl/core/integer_to_radix_string.sv */
// Top level of the integer to radix string converter: control, digit store and output register.
// Each digit comes from one full division of the number by the radix in the single bit-serial
// divider (one quotient bit per cycle); the stored digits are then read back most significant
// first through states EMIT_RD and EMIT_LD. A new number is taken only in the idle state, after
// the last character of the previous one has been loaded into the output register.
// Reset (arst_n, asynchronous): radix 10, lowercase letters, idle, no result pending.
`timescale 1ns / 1ps

module integer_to_radix_string #(
	parameter int MAX_DIGITS = itr_pkg::MAX_DIGITS_DEF,
	parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input item
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [itr_pkg::VALUE_W-1:0]      value,
	// result item
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [itr_pkg::CHAR_W-1:0]       digit_char,
	output logic                             last,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [itr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CNTW = $clog2(MAX_DIGITS + 1);

	itr_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [itr_pkg::RADIX_W-1:0] radix_q;
	logic                        upper_q;
	// Radix latched at input transfer, held for the whole conversion.
	logic [itr_pkg::RADIX_W-1:0] base_q;

	logic [CNTW-1:0] cnt_q;   // digits stored so far
	logic [AW-1:0]   ptr_q;   // next digit to read back, most significant first

	logic                       ovld_q;
	logic [itr_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;

	itr_pkg::div_ctrl_t          div_ctrl;
	itr_pkg::div_stat_t          div_stat;
	logic [itr_pkg::DIGIT_W-1:0] div_digit;

	logic                        ram_we;
	logic                        ram_re;
	logic [itr_pkg::DIGIT_W-1:0] ram_rdata;

	logic in_xfer;
	logic out_xfer;
	logic out_free;
	logic out_load;
	logic store_ok;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = ovld_q && !out_stall;
	assign out_free = !ovld_q || !out_stall;
	assign store_ok = (cnt_q < CNTW'(MAX_DIGITS));

	// Registers are always writable; the user must write them only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= itr_pkg::RADIX_RST;
			upper_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == itr_pkg::CFG_RADIX) begin
				radix_q <= cfg_data[itr_pkg::RADIX_W-1:0];
			end else begin
				upper_q <= cfg_data[0];
			end
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		div_ctrl.load = 1'b0;
		div_ctrl.cont = 1'b0;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			itr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					div_ctrl.load = 1'b1;
					state_d       = itr_pkg::ST_DIV;
				end
			end
			itr_pkg::ST_DIV: begin
				if (div_stat.done) begin
					// Keep only the least significant digits once the store is full.
					ram_we = store_ok;
					if (div_stat.quo_zero) begin
						state_d = itr_pkg::ST_EMIT_RD;
					end else begin
						div_ctrl.cont = 1'b1;
					end
				end
			end
			itr_pkg::ST_EMIT_RD: begin
				ram_re  = 1'b1;
				state_d = itr_pkg::ST_EMIT_LD;
			end
			itr_pkg::ST_EMIT_LD: begin
				// Hold the read data until the output register frees up.
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (ptr_q == '0) ? itr_pkg::ST_IDLE : itr_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = itr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itr_pkg::ST_IDLE;
			base_q  <= itr_pkg::RADIX_RST;
			cnt_q   <= '0;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				base_q <= itr_pkg::eff_radix(radix_q);
				cnt_q  <= '0;
			end else if (ram_we) begin
				cnt_q <= cnt_q + CNTW'(1);
			end
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (out_xfer) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// Read pointer: start at the most significant stored digit, walk down to zero.
	always_ff @(posedge clk) begin
		if (state_q == itr_pkg::ST_DIV && div_stat.done && div_stat.quo_zero) begin
			ptr_q <= store_ok ? cnt_q[AW-1:0] : AW'(cnt_q - CNTW'(1));
		end else if (out_load) begin
			ptr_q <= ptr_q - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= itr_pkg::digit_to_char(ram_rdata, upper_q);
			last_q <= (ptr_q == '0);
		end
	end

	assign out_valid  = ovld_q;
	assign digit_char = char_q;
	assign last       = last_q;

	itr_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (div_ctrl),
		.value (value[VALUE_BITS-1:0]),
		.base  (base_q),
		.stat  (div_stat),
		.digit (div_digit)
	);

	itr_ram #(
		.WIDTH(itr_pkg::DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_digit_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(div_digit),
		.re   (ram_re),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == itr_pkg::ST_DIV))
		else $error("input transfer did not start a division");

	a_done_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == itr_pkg::ST_DIV))
		else $error("divider finished outside the division state");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && ptr_q == '0) |=> (state_q == itr_pkg::ST_IDLE && last_q && ovld_q))
		else $error("final digit did not close the item");

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_DIGITS))
		else $error("digit count beyond store depth");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q |-> ((char_q >= 7'h30 && char_q <= 7'h39) ||
			(char_q >= 7'h41 && char_q <= 7'h5A) ||
			(char_q >= 7'h61 && char_q <= 7'h7A)))
		else $error("output character outside digit alphabet");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the integer to radix string converter.
`timescale 1ns / 1ps

module tb_top;

	localparam int VALUE_W    = itr_pkg::VALUE_W;
	localparam int DIGIT_W    = itr_pkg::DIGIT_W;
	localparam int CHAR_W     = itr_pkg::CHAR_W;
	localparam int RADIX_W    = itr_pkg::RADIX_W;
	localparam int CFG_IDX_W  = itr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = itr_pkg::CFG_DATA_W;

	// One emitted character as the output port carries it.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_beat_t;

	// One directed stimulus row: settings in force and the number to convert.
	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               upper;
		logic [VALUE_W-1:0] num;
	} stim_row_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               upper;
	} radix_setting_t;

	localparam int DIR_ROWS        = 24;
	localparam int PLAN_PHASES     = 10;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int DRAIN_CYCLES    = 300;
	localparam int MAX_REPORTS     = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [VALUE_W-1:0]    value;
	logic                  out_valid;
	logic                  out_stall;
	logic [CHAR_W-1:0]     digit_char;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Our own copy of the register file, updated at each config transfer.
	logic [RADIX_W-1:0] cur_radix = itr_pkg::RADIX_RST;
	logic               cur_upper = 1'b0;

	// Characters still owed by the block, oldest first.
	digit_beat_t expected_digits[$];
	int          fault_count = 0;
	bit          hold_off_req;

	// Directed rows. Rows with text carry the answer typed in; empty text means
	// the row is checked against the predictor instead.
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{6'd10, 1'b0, 63'd0},
		'{6'd10, 1'b0, 63'd7},
		'{6'd10, 1'b0, {63{1'b1}}},
		'{6'd10, 1'b0, 63'd1000},
		'{6'd16, 1'b0, {63{1'b1}}},
		'{6'd16, 1'b1, 63'hABCDEF},
		'{6'd16, 1'b1, 63'd0},
		'{6'd2,  1'b0, 63'd5},
		'{6'd2,  1'b0, {63{1'b1}}},
		'{6'd2,  1'b0, 63'h5555_5555_5555_5555},
		'{6'd2,  1'b0, 63'h2AAA_AAAA_AAAA_AAAA},
		'{6'd0,  1'b0, 63'd6},
		'{6'd1,  1'b1, 63'd1},
		'{6'd36, 1'b0, 63'd35},
		'{6'd36, 1'b0, {63{1'b1}}},
		'{6'd36, 1'b1, 63'd35},
		'{6'd36, 1'b1, 63'd1295},
		'{6'd37, 1'b1, 63'd35},
		'{6'd63, 1'b0, 63'd71},
		'{6'd3,  1'b0, {63{1'b1}}},
		'{6'd35, 1'b1, 63'd34},
		'{6'd8,  1'b0, 63'd8},
		'{6'd10, 1'b1, 63'd9},
		'{6'd11, 1'b0, 63'd10}
	};
	string dir_text [DIR_ROWS] = '{
		"0", "7", "9223372036854775807", "1000", {"7fff", "ffff", "ffff", "ffff"},
		"ABCDEF", "0", "101", "", "", "", "110", "1", "z", "", "Z", "ZZ", "Z", "1z", "",
		"Y", "10", "9", "a"
	};

	// Register settings of the random phases; the last phases pick their own.
	radix_setting_t phase_plan [PLAN_PHASES] = '{
		'{6'd2, 1'b1}, '{6'd36, 1'b0}, '{6'd0, 1'b0}, '{6'd63, 1'b1}, '{6'd16, 1'b1},
		'{6'd8, 1'b0}, '{6'd1, 1'b0}, '{6'd37, 1'b1}, '{6'd10, 1'b1}, '{6'd36, 1'b1}
	};

	integer_to_radix_string uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Count a failure; print only the first few in full.
	function automatic void note_mismatch(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("%0t ns: %s", $time, msg);
		end
	endfunction

	// Append one character to the tail of the owed list.
	function automatic void owe_digit(input digit_beat_t beat);
		expected_digits.insert(expected_digits.size(), beat);
	endfunction

	// Split a number into digits under the current settings and queue the
	// characters most significant first, flagging the final one.
	function automatic void predict_digits(input logic [VALUE_W-1:0] num);
		longint unsigned rest;
		longint unsigned base;
		logic [DIGIT_W-1:0] digs [64];
		int n;
		digit_beat_t beat;
		// Saturate out-of-range bases into 2..36.
		if (cur_radix < itr_pkg::RADIX_MIN) begin
			base = itr_pkg::RADIX_MIN;
		end else if (cur_radix > itr_pkg::RADIX_MAX) begin
			base = itr_pkg::RADIX_MAX;
		end else begin
			base = cur_radix;
		end
		rest = num;
		n = 0;
		// Zero still yields one digit.
		if (rest == 0) begin
			digs[0] = '0;
			n = 1;
		end
		while (rest != 0) begin
			if (n < 64) begin
				digs[n] = DIGIT_W'(rest % base);
				n++;
			end
			rest = rest / base;
		end
		for (int k = n - 1; k >= 0; k--) begin
			if (digs[k] < itr_pkg::DEC_DIGITS) begin
				beat.ch = itr_pkg::CHAR_ZERO + CHAR_W'(digs[k]);
			end else begin
				beat.ch = (cur_upper ? itr_pkg::CHAR_UPPER_A : itr_pkg::CHAR_LOWER_A)
					+ CHAR_W'(digs[k]) - CHAR_W'(itr_pkg::DEC_DIGITS);
			end
			beat.last = (k == 0);
			owe_digit(beat);
		end
	endfunction

	// Draw a number whose length is mostly short so long conversions stay rare.
	function automatic logic [VALUE_W-1:0] random_number();
		logic [63:0] raw;
		logic [63:0] mask;
		int bits;
		int pick;
		raw = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			return '0;
		end else if (pick < 8) begin
			bits = VALUE_W;
		end else if (pick < 22) begin
			bits = $urandom_range(17, VALUE_W - 1);
		end else begin
			bits = $urandom_range(1, 16);
		end
		mask = (64'd1 << bits) - 64'd1;
		// Force the top bit so the length really is 'bits'.
		raw = (raw & mask) | (64'd1 << (bits - 1));
		return raw[VALUE_W-1:0];
	endfunction

	// Sender gap: mostly back to back, sometimes short, rarely long.
	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			return 0;
		end else if (pick < 85) begin
			return $urandom_range(1, 3);
		end else if (pick < 95) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Offer one number; on its transfer queue either the typed answer or the
	// predicted one. Starts and ends on a falling edge.
	task automatic offer_value(input logic [VALUE_W-1:0] num, input string typed);
		int gap;
		digit_beat_t beat;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= num;
		// Hold the payload until the block takes it.
		do @(posedge clk); while (in_stall);
		if (typed.len() == 0) begin
			predict_digits(num);
		end else begin
			for (int i = 0; i < typed.len(); i++) begin
				beat.ch   = CHAR_W'(typed[i]);
				beat.last = (i == typed.len() - 1);
				owe_digit(beat);
			end
		end
		@(negedge clk);
	endtask

	// Drop the input and wait until every owed character has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_digits.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Write both registers back to back, tracking each transfer in the copy.
	task automatic program_settings(input logic [RADIX_W-1:0] r, input logic u);
		cfg_valid <= 1'b1;
		cfg_index <= itr_pkg::CFG_RADIX;
		cfg_data  <= CFG_DATA_W'(r);
		do @(posedge clk); while (!cfg_ready);
		cur_radix = r;
		@(negedge clk);
		cfg_index <= itr_pkg::CFG_LETTER_UPPER;
		cfg_data  <= CFG_DATA_W'(u);
		do @(posedge clk); while (!cfg_ready);
		cur_upper = u;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver pacing: runs of free flow, short stalls, a few long ones, and
	// on request one long hold-off so the block backs up into its input.
	initial begin : drain_pacing
		int  pick;
		int  span;
		logic stall_now;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_now = 1'b1;
				span = HOLD_OFF_CYCLES;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					stall_now = 1'b0;
					span = $urandom_range(1, 8);
				end else if (pick < 55) begin
					stall_now = 1'b0;
					span = $urandom_range(50, 200);
				end else if (pick < 90) begin
					stall_now = 1'b1;
					span = $urandom_range(1, 3);
				end else begin
					stall_now = 1'b1;
					span = $urandom_range(20, 80);
				end
			end
			out_stall <= stall_now;
			repeat (span) @(negedge clk);
		end
	end

	// Compare each character transfer with the oldest owed character.
	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_digits.size() == 0) begin
				note_mismatch($sformatf("unexpected char 0x%0h last %0b", digit_char, last));
			end else begin
				want = expected_digits.pop_front();
				if (digit_char !== want.ch) begin
					note_mismatch($sformatf("digit_char: expected 0x%0h got 0x%0h",
						want.ch, digit_char));
				end
				if (last !== want.last) begin
					note_mismatch($sformatf("last: expected %0b got %0b", want.last, last));
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		radix_setting_t setting;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		value        = '0;
		cfg_valid    = 1'b0;
		cfg_index    = itr_pkg::CFG_RADIX;
		cfg_data     = '0;
		hold_off_req = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows; the first ones run on the reset settings untouched.
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			if (row.radix != cur_radix || row.upper != cur_upper) begin
				settle();
				program_settings(row.radix, row.upper);
			end
			offer_value(row.num, dir_text[i]);
		end

		// Random phases, each under its own settings, written while idle.
		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			if (p < PLAN_PHASES) begin
				setting = phase_plan[p];
			end else begin
				setting.radix = RADIX_W'($urandom_range(0, 63));
				setting.upper = 1'($urandom_range(0, 1));
			end
			program_settings(setting.radix, setting.upper);
			// Ask the receiver for a long hold-off while items keep coming.
			if (p == 1 || p == 6) begin
				hold_off_req = 1'b1;
			end
			repeat (ITEMS_PER_PHASE) offer_value(random_number(), "");
		end

		// Drain, then give any stray output time to show up.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_digits.size() != 0) begin
			note_mismatch($sformatf("%0d chars never arrived", expected_digits.size()));
		end
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(80_000_000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
